>>> design/kcl_pkg.sv
package kcl_pkg;

    localparam int CODE_DIGITS = 4;
    localparam int CODE_W      = 4 * CODE_DIGITS;
    localparam int DCNT_W      = $clog2(CODE_DIGITS + 1);
    localparam int LOCK_W      = 32;
    localparam int CNT4_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [DCNT_W-1:0] DCNT_FULL = DCNT_W'(CODE_DIGITS);
    localparam logic [LOCK_W-1:0] LOCK_ONE  = LOCK_W'(1);
    localparam logic [CNT4_W-1:0] FAIL_MAX  = '1;

    localparam logic [1:0] REQ_KEY      = 2'd0;
    localparam logic [1:0] REQ_REMOTE   = 2'd1;
    localparam logic [1:0] REQ_SET_TEMP = 2'd2;
    localparam logic [1:0] REQ_TICK     = 2'd3;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_ENTER     = 4'd10;
    localparam logic [3:0] KEY_CLEAR     = 4'd11;

    localparam logic [CFG_IDX_W-1:0] REG_PERMANENT_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CODE_USES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS  = 2'd3;

    localparam logic [15:0]       RST_PERMANENT_CODE = 16'h1234;
    localparam logic [3:0]        RST_TEMP_CODE_USES = 4'd2;
    localparam logic [3:0]        RST_MAX_FAILURES   = 4'd3;
    localparam logic [LOCK_W-1:0] RST_LOCKOUT_TICKS  = LOCK_W'(3000);

    typedef enum logic [3:0] {
        ST_IGNORED    = 4'd0,
        ST_DIGIT      = 4'd1,
        ST_CLEARED    = 4'd2,
        ST_TEMP_MATCH = 4'd3,
        ST_PERM_MATCH = 4'd4,
        ST_WRONG      = 4'd5,
        ST_LOCK_START = 4'd6,
        ST_REMOTE     = 4'd7,
        ST_TEMP_SET   = 4'd8,
        ST_REFUSED    = 4'd9,
        ST_LOCK_END   = 4'd10
    } status_t;

    typedef struct packed {
        logic [15:0]       permanent_code;
        logic [3:0]        temp_code_uses;
        logic [3:0]        max_failures;
        logic [LOCK_W-1:0] lockout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  key_code;
        logic        remote_open;
        logic [15:0] new_temp_code;
    } req_item_t;

    typedef struct packed {
        status_t           status;
        logic              bolt_is_open;
        logic              is_locked_out;
        logic [CNT4_W-1:0] failure_count;
        logic [CNT4_W-1:0] temp_uses_left;
    } result_t;

endpackage

>>> design/kcl_if.sv
interface kcl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  key_code;
    logic        remote_open;
    logic [15:0] new_temp_code;

    modport source (output valid, output req_type, output key_code, output remote_open,
                    output new_temp_code, input ready);
    modport sink   (input valid, input req_type, input key_code, input remote_open,
                    input new_temp_code, output ready);
endinterface

interface kcl_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic       bolt_is_open;
    logic       is_locked_out;
    logic [3:0] failure_count;
    logic [3:0] temp_uses_left;

    modport source (output valid, output status, output bolt_is_open, output is_locked_out,
                    output failure_count, output temp_uses_left, input ready);
    modport sink   (input valid, input status, input bolt_is_open, input is_locked_out,
                    input failure_count, input temp_uses_left, output ready);
endinterface

interface kcl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/kcl_cfg_regs.sv
module kcl_cfg_regs
    import kcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kcl_cfg_if.sink    cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.permanent_code <= RST_PERMANENT_CODE;
            regs_reg.temp_code_uses <= RST_TEMP_CODE_USES;
            regs_reg.max_failures   <= RST_MAX_FAILURES;
            regs_reg.lockout_ticks  <= RST_LOCKOUT_TICKS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PERMANENT_CODE: regs_reg.permanent_code <= cfg.data[15:0];
                REG_TEMP_CODE_USES: regs_reg.temp_code_uses <= cfg.data[3:0];
                REG_MAX_FAILURES:   regs_reg.max_failures   <= cfg.data[3:0];
                REG_LOCKOUT_TICKS:  regs_reg.lockout_ticks  <= cfg.data[LOCK_W-1:0];
                default:            regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

>>> design/kcl_engine.sv
module kcl_engine
    import kcl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      regs,
    input  logic      take,
    input  req_item_t item,
    output result_t   result
);

    logic              bolt_reg,     bolt_next;
    logic [CODE_W-1:0] buf_reg,      buf_next;
    logic [DCNT_W-1:0] dcnt_reg,     dcnt_next;
    logic [CODE_W-1:0] temp_reg,     temp_next;
    logic [CNT4_W-1:0] uses_reg,     uses_next;
    logic [CNT4_W-1:0] fail_reg,     fail_next;
    logic [LOCK_W-1:0] lock_reg,     lock_next;

    logic              locked;
    logic              full;
    logic              temp_hit;
    logic              perm_hit;
    logic [CNT4_W-1:0] fail_inc;
    logic [CNT4_W-1:0] uses_dec;
    status_t           status;

    assign locked   = (lock_reg != '0);
    assign full     = (dcnt_reg == DCNT_FULL);
    assign temp_hit = full && (uses_reg != '0) && (buf_reg == temp_reg);
    assign perm_hit = full && (buf_reg == regs.permanent_code[CODE_W-1:0]);
    assign fail_inc = (fail_reg == FAIL_MAX) ? fail_reg : fail_reg + CNT4_W'(1);
    assign uses_dec = uses_reg - CNT4_W'(1);

    always_comb
    begin
        bolt_next = bolt_reg;
        buf_next  = buf_reg;
        dcnt_next = dcnt_reg;
        temp_next = temp_reg;
        uses_next = uses_reg;
        fail_next = fail_reg;
        lock_next = lock_reg;
        status    = ST_IGNORED;

        if (item.req_type == REQ_TICK)
        begin
            if (locked)
            begin
                lock_next = lock_reg - LOCK_ONE;
                if (lock_reg == LOCK_ONE)
                begin
                    fail_next = '0;
                    status    = ST_LOCK_END;
                end
            end
        end
        else if (locked)
        begin
            status = ST_REFUSED;
        end
        else if (item.req_type == REQ_KEY)
        begin
            if (item.key_code <= KEY_DIGIT_MAX)
            begin
                if (!full)
                begin
                    buf_next  = {buf_reg[CODE_W-5:0], item.key_code};
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                    status    = ST_DIGIT;
                end
            end
            else if (item.key_code == KEY_ENTER)
            begin
                buf_next  = '0;
                dcnt_next = '0;
                if (temp_hit)
                begin
                    uses_next = uses_dec;
                    if (uses_dec == '0)
                    begin
                        temp_next = '0;
                    end
                    fail_next = '0;
                    bolt_next = !bolt_reg;
                    status    = ST_TEMP_MATCH;
                end
                else if (perm_hit)
                begin
                    fail_next = '0;
                    bolt_next = !bolt_reg;
                    status    = ST_PERM_MATCH;
                end
                else
                begin
                    fail_next = fail_inc;
                    if (fail_inc >= regs.max_failures)
                    begin
                        lock_next = (regs.lockout_ticks == '0) ? LOCK_ONE : regs.lockout_ticks;
                        status    = ST_LOCK_START;
                    end
                    else
                    begin
                        status = ST_WRONG;
                    end
                end
            end
            else if (item.key_code == KEY_CLEAR)
            begin
                buf_next  = '0;
                dcnt_next = '0;
                status    = ST_CLEARED;
            end
        end
        else if (dcnt_reg != '0)
        begin
            status = ST_REFUSED;
        end
        else if (item.req_type == REQ_REMOTE)
        begin
            bolt_next = item.remote_open;
            status    = ST_REMOTE;
        end
        else
        begin
            temp_next = item.new_temp_code[CODE_W-1:0];
            uses_next = regs.temp_code_uses;
            fail_next = '0;
            buf_next  = '0;
            dcnt_next = '0;
            status    = ST_TEMP_SET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bolt_reg <= 1'b0;
            buf_reg  <= '0;
            dcnt_reg <= '0;
            temp_reg <= '0;
            uses_reg <= '0;
            fail_reg <= '0;
            lock_reg <= '0;
        end
        else if (take)
        begin
            bolt_reg <= bolt_next;
            buf_reg  <= buf_next;
            dcnt_reg <= dcnt_next;
            temp_reg <= temp_next;
            uses_reg <= uses_next;
            fail_reg <= fail_next;
            lock_reg <= lock_next;
        end
    end

    assign result.status         = status;
    assign result.bolt_is_open   = bolt_next;
    assign result.is_locked_out  = (lock_next != '0);
    assign result.failure_count  = fail_next;
    assign result.temp_uses_left = uses_next;

endmodule

>>> design/kcl_out_stage.sv
module kcl_out_stage
    import kcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    result,
    output logic       can_take,
    input  logic       take,
    kcl_res_if.source  res
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_take   = !valid_reg || res.ready;
    assign valid_next = take || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= result;
        end
    end

    assign res.valid          = valid_reg;
    assign res.status         = data_reg.status;
    assign res.bolt_is_open   = data_reg.bolt_is_open;
    assign res.is_locked_out  = data_reg.is_locked_out;
    assign res.failure_count  = data_reg.failure_count;
    assign res.temp_uses_left = data_reg.temp_uses_left;

endmodule

>>> design/keypad_code_lock_controller_unit.sv
// Code lock controller: takes one request per cycle (keypad key, remote lock/unlock, remote
// set-temp, tick) and returns one result transaction for each, in order, in the cycle after the
// request is taken. The lock state updates at the edge the request is taken and the result
// is held in an output register, so requests keep flowing while that register is empty or
// being drained in the same cycle; a stalled result sink holds off new requests. Configuration
// writes are taken every cycle and apply to requests taken afterwards.
module keypad_code_lock_controller_unit
    import kcl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kcl_req_if.sink   req,
    kcl_res_if.source res,
    kcl_cfg_if.sink   cfg
);

    cfg_t      regs;
    req_item_t item;
    result_t   result;
    logic      can_take;
    logic      take;

    assign req.ready = can_take;
    assign take      = req.valid && can_take;

    assign item.req_type      = req.req_type;
    assign item.key_code      = req.key_code;
    assign item.remote_open   = req.remote_open;
    assign item.new_temp_code = req.new_temp_code;

    kcl_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    kcl_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .take   (take),
        .item   (item),
        .result (result)
    );

    kcl_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .can_take (can_take),
        .take     (take),
        .res      (res)
    );

endmodule

>>> design/kcl_checker.sv
module kcl_checker
    import kcl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [3:0] res_status,
    input logic       res_locked,
    input logic [3:0] res_fail
);

    a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status))
        else $error("result changed while stalled");

    a_req_to_res : assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> res_valid)
        else $error("taken request gave no result");

    a_lock_start : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_LOCK_START) |-> res_locked)
        else $error("lockout start without lockout");

    a_lock_end : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_LOCK_END) |-> !res_locked && (res_fail == 4'd0))
        else $error("lockout end left lockout or failures");

    a_match_clears : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((res_status == ST_TEMP_MATCH) || (res_status == ST_PERM_MATCH))
        |-> (res_fail == 4'd0) && !res_locked)
        else $error("match kept failures");

endmodule

bind keypad_code_lock_controller_unit kcl_checker u_kcl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_status (res.status),
    .res_locked (res.is_locked_out),
    .res_fail   (res.failure_count)
);

>>> verif/keypad_code_lock_controller_unit_test.sv
module keypad_code_lock_controller_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kcl_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kcl_req_if req_if();
    kcl_res_if res_if();
    kcl_cfg_if cfg_if();

    logic                  req_valid = 1'b0;
    req_item_t             req_cur   = '0;
    logic                  res_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    assign req_if.valid         = req_valid;
    assign req_if.req_type      = req_cur.req_type;
    assign req_if.key_code      = req_cur.key_code;
    assign req_if.remote_open   = req_cur.remote_open;
    assign req_if.new_temp_code = req_cur.new_temp_code;
    assign res_if.ready         = res_ready;
    assign cfg_if.valid         = cfg_valid;
    assign cfg_if.index         = cfg_index;
    assign cfg_if.data          = cfg_data;

    keypad_code_lock_controller_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // register shadows
    logic [15:0]       sh_perm  = RST_PERMANENT_CODE;
    logic [3:0]        sh_uses  = RST_TEMP_CODE_USES;
    logic [3:0]        sh_maxf  = RST_MAX_FAILURES;
    logic [LOCK_W-1:0] sh_ticks = RST_LOCKOUT_TICKS;

    // lock state as predicted
    logic              lk_bolt = 1'b0;
    logic [CODE_W-1:0] lk_buf  = '0;
    logic [DCNT_W-1:0] lk_cnt  = '0;
    logic [15:0]       lk_temp = '0;
    logic [3:0]        lk_uses = '0;
    logic [3:0]        lk_fail = '0;
    logic [LOCK_W-1:0] lk_left = '0;

    req_item_t pending_reqs[$];
    result_t   due_replies[$];
    int        n_queued = 0;
    int        n_taken = 0;
    int        err_count = 0;
    int        src_gap = 0;
    int        snk_gap = 0;
    int        stall_ask = 0;
    int        stall_seen = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;
    bit        calm = 1'b0;
    logic [15:0] gen_temp = '0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic result_t lock_step(input req_item_t rq);
        result_t r;
        status_t st;
        logic    full;
        st = ST_IGNORED;
        full = (lk_cnt == DCNT_FULL);
        if (rq.req_type == REQ_TICK)
        begin
            if (lk_left != '0)
            begin
                lk_left = lk_left - 1'b1;
                if (lk_left == '0)
                begin
                    lk_fail = '0;
                    st = ST_LOCK_END;
                end
            end
        end
        else if (lk_left != '0)
            st = ST_REFUSED;
        else if (rq.req_type == REQ_KEY)
        begin
            if (rq.key_code <= KEY_DIGIT_MAX)
            begin
                if (lk_cnt < DCNT_FULL)
                begin
                    lk_buf = {lk_buf[CODE_W-5:0], rq.key_code};
                    lk_cnt = lk_cnt + 1'b1;
                    st = ST_DIGIT;
                end
            end
            else if (rq.key_code == KEY_ENTER)
            begin
                if (full && lk_uses != '0 && lk_buf == lk_temp)
                begin
                    lk_uses = lk_uses - 1'b1;
                    if (lk_uses == '0)
                        lk_temp = '0;
                    lk_fail = '0;
                    lk_bolt = ~lk_bolt;
                    st = ST_TEMP_MATCH;
                end
                else if (full && lk_buf == sh_perm)
                begin
                    lk_fail = '0;
                    lk_bolt = ~lk_bolt;
                    st = ST_PERM_MATCH;
                end
                else
                begin
                    if (lk_fail != FAIL_MAX)
                        lk_fail = lk_fail + 1'b1;
                    if (lk_fail >= sh_maxf)
                    begin
                        lk_left = (sh_ticks == '0) ? LOCK_ONE : sh_ticks;
                        st = ST_LOCK_START;
                    end
                    else
                        st = ST_WRONG;
                end
                lk_buf = '0;
                lk_cnt = '0;
            end
            else if (rq.key_code == KEY_CLEAR)
            begin
                lk_buf = '0;
                lk_cnt = '0;
                st = ST_CLEARED;
            end
        end
        else if (lk_cnt != '0)
            st = ST_REFUSED;
        else if (rq.req_type == REQ_REMOTE)
        begin
            lk_bolt = rq.remote_open;
            st = ST_REMOTE;
        end
        else
        begin
            lk_temp = rq.new_temp_code;
            lk_uses = sh_uses;
            lk_fail = '0;
            lk_buf = '0;
            lk_cnt = '0;
            st = ST_TEMP_SET;
        end
        r.status = st;
        r.bolt_is_open = lk_bolt;
        r.is_locked_out = (lk_left != '0);
        r.failure_count = lk_fail;
        r.temp_uses_left = lk_uses;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [15:0] rand_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    task automatic push_req(input logic [1:0] rt, input logic [3:0] key, input logic ro,
                            input logic [15:0] nt);
        req_item_t it;
        it.req_type = rt;
        it.key_code = key;
        it.remote_open = ro;
        it.new_temp_code = nt;
        pending_reqs.push_back(it);
        n_queued++;
    endtask

    task automatic push_key(input logic [3:0] key);
        push_req(REQ_KEY, key, 1'($urandom), 16'($urandom));
    endtask

    task automatic push_set_temp(input logic [15:0] code);
        gen_temp = code;
        push_req(REQ_SET_TEMP, 4'($urandom), 1'($urandom), code);
    endtask

    // digits of a code, first nibble first, then enter; non-digit nibbles become noise digits
    task automatic push_code(input logic [15:0] code, input int ndig);
        logic [3:0] nib;
        for (int i = 0; i < ndig; i++)
        begin
            nib = (i < 4) ? 4'(code >> (12 - 4 * i)) : 4'($urandom_range(0, 9));
            if (nib > KEY_DIGIT_MAX)
                nib = 4'($urandom_range(0, 9));
            push_key(nib);
        end
        push_key(KEY_ENTER);
    endtask

    task automatic add_sequence();
        int          pick;
        int          len;
        int          cap;
        logic [15:0] target;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: target = sh_perm;
                5, 6, 7:       target = gen_temp;
                default:       target = rand_bcd();
            endcase
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
            if ($urandom_range(0, 9) == 0)
            begin
                push_key(4'($urandom_range(0, 9)));
                push_key(KEY_CLEAR);
            end
            push_code(target, len);
        end
        else if (pick < 50)
            push_req(REQ_REMOTE, 4'($urandom), 1'($urandom), 16'($urandom));
        else if (pick < 60)
            push_set_temp(($urandom_range(0, 3) == 0) ? 16'($urandom) : rand_bcd());
        else if (pick < 78)
        begin
            cap = (sh_ticks < 20) ? int'(sh_ticks) + 2 : 20;
            len = $urandom_range(1, cap);
            repeat (len)
                push_req(REQ_TICK, 4'($urandom), 1'($urandom), 16'($urandom));
        end
        else if (pick < 85)
            push_key(KEY_CLEAR);
        else
        begin
            repeat ($urandom_range(1, 4))
                push_req(2'($urandom), 4'($urandom), 1'($urandom), 16'($urandom));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PERMANENT_CODE: sh_perm = val[15:0];
            REG_TEMP_CODE_USES: sh_uses = val[3:0];
            REG_MAX_FAILURES:   sh_maxf = val[3:0];
            REG_LOCKOUT_TICKS:  sh_ticks = val;
        endcase
    endtask

    task automatic wait_drain();
        while (n_taken != n_queued || due_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] perm, input logic [3:0] uses,
                             input logic [3:0] maxf, input logic [LOCK_W-1:0] ticks,
                             input int n, input bit squeeze);
        int goal;
        wait_drain();
        write_reg(REG_PERMANENT_CODE, 32'(perm));
        write_reg(REG_TEMP_CODE_USES, 32'(uses));
        write_reg(REG_MAX_FAILURES, 32'(maxf));
        write_reg(REG_LOCKOUT_TICKS, ticks);
        if (squeeze)
            stall_ask++;
        goal = n_queued + n;
        while (n_queued < goal)
            add_sequence();
    endtask

    // request driver
    always @(posedge clk)
    begin : drv
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = req_valid;
            if (req_valid && req_if.ready)
            begin
                due_replies.push_back(lock_step(req_cur));
                n_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_reqs.size() != 0)
                begin
                    if (!calm && $urandom_range(0, 11) == 0)
                        src_gap = $urandom_range(0, 15);
                    else
                    begin
                        req_cur <= pending_reqs.pop_front();
                        nxt_valid = 1'b1;
                    end
                end
            end
            req_valid <= nxt_valid;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : mon
        result_t want;
        logic    nxt_ready;
        if (rst_n)
        begin
            if (res_ready && res_if.valid)
            begin
                if (due_replies.size() == 0)
                    report("result transaction with nothing expected");
                else
                begin
                    want = due_replies.pop_front();
                    if (res_if.status !== want.status)
                        report($sformatf("status got %0d want %0d", res_if.status, want.status));
                    if (res_if.bolt_is_open !== want.bolt_is_open)
                        report($sformatf("bolt_is_open got %0b want %0b",
                                         res_if.bolt_is_open, want.bolt_is_open));
                    if (res_if.is_locked_out !== want.is_locked_out)
                        report($sformatf("is_locked_out got %0b want %0b",
                                         res_if.is_locked_out, want.is_locked_out));
                    if (res_if.failure_count !== want.failure_count)
                        report($sformatf("failure_count got %0d want %0d",
                                         res_if.failure_count, want.failure_count));
                    if (res_if.temp_uses_left !== want.temp_uses_left)
                        report($sformatf("temp_uses_left got %0d want %0d",
                                         res_if.temp_uses_left, want.temp_uses_left));
                end
            end
            if (stall_seen != stall_ask)
            begin
                stall_seen = stall_ask;
                stall_left = LONG_HOLD;
            end
            nxt_ready = 1'b1;
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                nxt_ready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                snk_gap = $urandom_range(0, 15);
                nxt_ready = 1'b0;
            end
            res_ready <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_if.ready) || (res_ready && res_if.valid)
            || (cfg_valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("keypad_code_lock_controller_unit verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: ignored keys, short entry, pending digits, both codes
        push_req(REQ_TICK, 4'd0, 1'b0, 16'h0000);
        push_key(4'd12);
        push_key(4'd15);
        push_key(KEY_CLEAR);
        push_key(KEY_ENTER);
        push_key(4'd1);
        push_req(REQ_REMOTE, 4'd0, 1'b1, 16'h0000);
        push_req(REQ_SET_TEMP, 4'd0, 1'b0, 16'h5678);
        push_key(4'd2);
        push_key(4'd3);
        push_key(4'd4);
        push_key(4'd9);
        push_key(KEY_ENTER);
        push_req(REQ_REMOTE, 4'd0, 1'b0, 16'h0000);
        push_req(REQ_REMOTE, 4'd0, 1'b1, 16'h0000);
        push_set_temp(16'h5678);
        push_code(16'h5678, 4);
        push_code(16'h5678, 4);
        push_set_temp(16'hABCD);

        // lockout on first failure, two ticks long
        wait_drain();
        write_reg(REG_MAX_FAILURES, 32'd1);
        write_reg(REG_LOCKOUT_TICKS, 32'd2);
        push_key(KEY_ENTER);
        push_key(4'd7);
        push_req(REQ_TICK, 4'd0, 1'b0, 16'h0000);
        push_req(REQ_TICK, 4'd0, 1'b0, 16'h0000);

        run_phase(16'h2580, 4'd3, 4'd3, 32'd5, 110, 1'b0);
        run_phase(16'h0000, 4'd15, 4'd1, 32'd1, 90, 1'b0);
        run_phase(16'h9999, 4'd1, 4'd15, 32'd4, 90, 1'b0);
        run_phase(rand_bcd(), 4'd0, 4'd0, 32'd0, 80, 1'b0);
        run_phase(16'hFFFF, 4'd2, 4'd2, 32'd3, 80, 1'b0);
        run_phase(rand_bcd(), 4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
                  32'($urandom_range(1, 8)), 110, 1'b1);
        wait_drain();
        calm = 1'b1;
        run_phase(16'h4321, 4'd7, 4'd15, 32'hFFFF_FFFF, 80, 1'b0);

        wait_drain();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("keypad_code_lock_controller_unit verification clean");
        else
            $display("keypad_code_lock_controller_unit verification failed");
        $finish;
    end

endmodule
